// File: hw/rtl/radio_packet_deframer_address_filter_top_defines.svh
// Assertion macros for the deframer RTL; only the parser includes this file.
`ifndef RADIO_PACKET_DEFRAMER_ADDRESS_FILTER_TOP_DEFINES_SVH
`define RADIO_PACKET_DEFRAMER_ADDRESS_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RPDAF_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication, disabled during reset.
`define RPDAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define RPDAF_ASSERT_IMM(label, clk, rst_n, ante, cons)
`define RPDAF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/rpdaf_pkg.sv
// Types and constants for the radio packet deframer and address filter.
package rpdaf_pkg;

    // Frame length limits
    localparam logic [7:0] MAX_LEN     = 8'd66;
    localparam logic [6:0] HEADER_LEN  = 7'd3;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROMISC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_SENT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_REQUEST = 3'd4;

    typedef struct packed {
        logic [7:0] fifo_byte;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sender_id;
        logic [7:0] target_id;
        logic       ack_received;
        logic       ack_requested;
        logic [5:0] data_length;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] node_address;
        logic       promiscuous;
        logic [7:0] broadcast_address;
        logic [7:0] ack_sent_mask;
        logic [7:0] ack_request_mask;
    } cfg_t;

endpackage

// File: hw/rtl/rpdaf_cfg_regs.sv
// Configuration register bank for the deframer.
module rpdaf_cfg_regs
    import rpdaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes always complete in one beat
    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NODE_ADDR:   cfg_next.node_address      = cfg_data;
                REG_PROMISC:     cfg_next.promiscuous       = cfg_data[0];
                REG_BCAST_ADDR:  cfg_next.broadcast_address = cfg_data;
                REG_ACK_SENT:    cfg_next.ack_sent_mask     = cfg_data;
                REG_ACK_REQUEST: cfg_next.ack_request_mask  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_address      <= 8'd0;
            cfg_reg.promiscuous       <= 1'b0;
            cfg_reg.broadcast_address <= 8'd255;
            cfg_reg.ack_sent_mask     <= 8'd128;
            cfg_reg.ack_request_mask  <= 8'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/rpdaf_parser.sv
// Frame phase machine: filters the target and builds header, payload and reject results.
`include "radio_packet_deframer_address_filter_top_defines.svh"
module rpdaf_parser
    import rpdaf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_beat_t  beat,
    input  cfg_t      cfg,
    output logic      res_valid,
    output out_beat_t res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TARGET  = 3'd1;
    localparam logic [2:0] PH_SENDER  = 3'd2;
    localparam logic [2:0] PH_CONTROL = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0] phase_reg,  phase_next;
    logic [6:0] len_reg,    len_next;
    logic [5:0] count_reg,  count_next;
    logic [7:0] sender_reg, sender_next;
    logic [7:0] target_reg, target_next;
    logic [1:0] ack_reg,    ack_next;

    logic [6:0] dlen;
    logic [6:0] idx_inc;
    logic [1:0] ack_new;
    logic       addr_ok;
    logic       fin;

    // Payload length derived from the clamped frame length
    assign dlen    = (len_reg >= HEADER_LEN) ? (len_reg - HEADER_LEN) : 7'd0;
    assign idx_inc = {1'b0, count_reg} + 7'd1;
    assign fin     = (idx_inc >= dlen);
    assign ack_new = {|(beat.fifo_byte & cfg.ack_request_mask),
                      |(beat.fifo_byte & cfg.ack_sent_mask)};
    assign addr_ok = cfg.promiscuous || (beat.fifo_byte == cfg.node_address) ||
                     (beat.fifo_byte == cfg.broadcast_address);

    // Next state and result for one accepted beat
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        sender_next = sender_reg;
        target_next = target_reg;
        ack_next    = ack_reg;
        res_valid   = 1'b0;

        res.kind          = KIND_HEADER;
        res.sender_id     = sender_reg;
        res.target_id     = target_reg;
        res.ack_received  = ack_reg[0];
        res.ack_requested = ack_reg[1];
        res.data_length   = dlen[5:0];
        res.data_byte     = 8'd0;
        res.byte_index    = 6'd0;
        res.last          = 1'b0;

        if (accept)
        begin
            if (beat.frame_start)
            begin
                len_next    = (beat.fifo_byte > MAX_LEN) ? MAX_LEN[6:0]
                                                         : beat.fifo_byte[6:0];
                count_next  = 6'd0;
                sender_next = 8'd0;
                target_next = 8'd0;
                ack_next    = 2'd0;
                phase_next  = PH_TARGET;
            end
            else
            begin
                case (phase_reg)
                    PH_TARGET:
                    begin
                        target_next = beat.fifo_byte;
                        if (!addr_ok || (len_reg < HEADER_LEN))
                        begin
                            sender_next       = 8'd0;
                            ack_next          = 2'd0;
                            len_next          = 7'd0;
                            res_valid         = 1'b1;
                            res.kind          = KIND_REJECT;
                            res.sender_id     = 8'd0;
                            res.target_id     = beat.fifo_byte;
                            res.ack_received  = 1'b0;
                            res.ack_requested = 1'b0;
                            res.data_length   = 6'd0;
                            res.last          = 1'b1;
                            phase_next        = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SENDER;
                        end
                    end
                    PH_SENDER:
                    begin
                        sender_next = beat.fifo_byte;
                        phase_next  = PH_CONTROL;
                    end
                    PH_CONTROL:
                    begin
                        ack_next          = ack_new;
                        count_next        = 6'd0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_HEADER;
                        res.ack_received  = ack_new[0];
                        res.ack_requested = ack_new[1];
                        res.last          = (dlen == 7'd0);
                        phase_next        = (dlen == 7'd0) ? PH_IDLE : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_PAYLOAD;
                        res.data_byte  = beat.fifo_byte;
                        res.byte_index = count_reg;
                        res.last       = fin;
                        count_next     = idx_inc[5:0];
                        if (fin)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_reg    <= 7'd0;
            count_reg  <= 6'd0;
            sender_reg <= 8'd0;
            target_reg <= 8'd0;
            ack_reg    <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sender_reg <= sender_next;
            target_reg <= target_next;
            ack_reg    <= ack_next;
        end
    end

    // A reject always closes the frame with cleared sender and length
    `RPDAF_ASSERT_IMM(a_reject_closes, clk, rst_n, res_valid && (res.kind == KIND_REJECT), res.last && (res.sender_id == 8'd0) && (res.data_length == 6'd0))
    // A header with payload moves the machine into payload phase
    `RPDAF_ASSERT_NXT(a_header_to_payload, clk, rst_n, res_valid && (res.kind == KIND_HEADER) && !res.last, phase_reg == PH_PAYLOAD)
    // Payload index stays inside the announced length
    `RPDAF_ASSERT_IMM(a_index_in_range, clk, rst_n, res_valid && (res.kind == KIND_PAYLOAD), res.byte_index < res.data_length)
    // Payload phase only exists for frames with at least one payload byte
    `RPDAF_ASSERT_IMM(a_payload_len, clk, rst_n, phase_reg == PH_PAYLOAD, len_reg > HEADER_LEN)

endmodule

// File: hw/rtl/rpdaf_out_stage.sv
// Output result register with valid/ready toward the consumer.
module rpdaf_out_stage
    import rpdaf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  out_beat_t res,
    output logic      load_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg,  out_data_next;

    // Upstream may move whenever the register is empty or draining
    assign load_ready = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// File: hw/rtl/radio_packet_deframer_address_filter_top.sv
// Top level of the radio packet deframer with address filter.
// A result is registered in the output stage in the cycle after its input beat is accepted.
// The block takes one input beat per cycle while in_ready is high.
// in_ready drops only while the output register holds a result that is not taken.
// Reset clears the phase machine to idle and loads the register defaults.
module radio_packet_deframer_address_filter_top
    import rpdaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t      cfg;
    logic      res_valid;
    out_beat_t res;
    logic      accept;

    assign accept = in_valid && in_ready;

    rpdaf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpdaf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .beat      (in_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    rpdaf_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .load_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// File: sim/tb_radio_packet_deframer_address_filter_top.sv
// Self-checking testbench for the radio packet deframer and address filter.
module tb_radio_packet_deframer_address_filter_top;
    import rpdaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 40;
    localparam int SETTLE_CYCLES   = 3;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_TARGET,
        FR_SENDER,
        FR_CONTROL,
        FR_PAYLOAD
    } frame_phase_e;

    // One directed beat; pinned rows carry a hand-written result
    typedef struct {
        logic [7:0] fifo_byte;
        bit         frame_start;
        bit         pinned;
        out_beat_t  result;
    } script_row_t;

    localparam out_beat_t NO_RESULT = '0;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_beat_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // Predictor state and register shadow
    frame_phase_e frame_phase;
    logic [6:0]   frame_len;
    logic [5:0]   pay_count;
    logic [7:0]   frame_sender;
    logic [7:0]   frame_target;
    logic [1:0]   ack_bits;
    cfg_t         shadow_cfg;

    out_beat_t expected_results[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        stall_pct;
    bit        hold_off_req;
    int        frame_beats_sent;
    bit        pinned_now;
    out_beat_t pinned_result;

    // Monitor scratch
    bit        produced;
    out_beat_t predicted;
    out_beat_t want;

    // Directed table: reset register values (node 0, broadcast FF, masks 80/40)
    script_row_t directed_rows [25] = '{
        '{8'hAA, 1'b0, 1'b0, NO_RESULT},    // stray byte while idle
        '{8'h03, 1'b1, 1'b0, NO_RESULT},    // empty payload frame
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hC0, 1'b0, 1'b1,
          '{KIND_HEADER, 8'hFF, 8'h00, 1'b1, 1'b1, 6'd0, 8'h00, 6'd0, 1'b1}},
        '{8'h55, 1'b0, 1'b0, NO_RESULT},    // byte after frame end
        '{8'h02, 1'b1, 1'b0, NO_RESULT},    // short frame to broadcast
        '{8'hFF, 1'b0, 1'b1,
          '{KIND_REJECT, 8'h00, 8'hFF, 1'b0, 1'b0, 6'd0, 8'h00, 6'd0, 1'b1}},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},    // clamped length, foreign target
        '{8'h12, 1'b0, 1'b1,
          '{KIND_REJECT, 8'h00, 8'h12, 1'b0, 1'b0, 6'd0, 8'h00, 6'd0, 1'b1}},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},    // clamped length, broadcast
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h3F, 1'b0, 1'b1,
          '{KIND_HEADER, 8'h00, 8'hFF, 1'b0, 1'b0, 6'd63, 8'h00, 6'd0, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h05, 1'b1, 1'b0, NO_RESULT},    // restart mid-frame
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{8'h77, 1'b0, 1'b0, NO_RESULT},    // stray byte
        '{8'h00, 1'b1, 1'b0, NO_RESULT},    // zero length to own address
        '{8'h00, 1'b0, 1'b1,
          '{KIND_REJECT, 8'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 6'd0, 1'b1}}
    };

    radio_packet_deframer_address_filter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result beat built from the current frame state
    function automatic out_beat_t frame_result(input logic [1:0] kind, input logic [7:0] dbyte,
                                               input logic [5:0] idx, input logic fin);
        out_beat_t r;
        logic [6:0] dlen;
        dlen = (frame_len >= HEADER_LEN) ? frame_len - HEADER_LEN : 7'd0;
        r.kind          = kind;
        r.sender_id     = frame_sender;
        r.target_id     = frame_target;
        r.ack_received  = ack_bits[0];
        r.ack_requested = ack_bits[1];
        r.data_length   = dlen[5:0];
        r.data_byte     = dbyte;
        r.byte_index    = idx;
        r.last          = fin;
        return r;
    endfunction

    // Deframer predictor: one accepted byte in, zero or one result out
    function automatic void deframe_beat(input in_beat_t beat, output bit has_result,
                                         output out_beat_t res);
        logic [7:0] b;
        bit         fin;
        b = beat.fifo_byte;
        has_result = 1'b0;
        res = '0;
        if (beat.frame_start)
        begin
            frame_len    = (b > MAX_LEN) ? MAX_LEN[6:0] : b[6:0];
            pay_count    = '0;
            frame_sender = '0;
            frame_target = '0;
            ack_bits     = '0;
            frame_phase  = FR_TARGET;
        end
        else
        begin
            case (frame_phase)
                FR_TARGET:
                begin
                    frame_target = b;
                    if (!(shadow_cfg.promiscuous || b == shadow_cfg.node_address ||
                          b == shadow_cfg.broadcast_address) || frame_len < HEADER_LEN)
                    begin
                        frame_sender = '0;
                        ack_bits     = '0;
                        frame_len    = '0;
                        has_result   = 1'b1;
                        res          = frame_result(KIND_REJECT, 8'h00, 6'd0, 1'b1);
                        frame_phase  = FR_IDLE;
                    end
                    else
                    begin
                        frame_phase = FR_SENDER;
                    end
                end
                FR_SENDER:
                begin
                    frame_sender = b;
                    frame_phase  = FR_CONTROL;
                end
                FR_CONTROL:
                begin
                    ack_bits    = {|(b & shadow_cfg.ack_request_mask),
                                   |(b & shadow_cfg.ack_sent_mask)};
                    pay_count   = '0;
                    fin         = (frame_len == HEADER_LEN);
                    has_result  = 1'b1;
                    res         = frame_result(KIND_HEADER, 8'h00, 6'd0, fin);
                    frame_phase = fin ? FR_IDLE : FR_PAYLOAD;
                end
                FR_PAYLOAD:
                begin
                    fin        = (int'(pay_count) + 1 >= int'(frame_len) - int'(HEADER_LEN));
                    has_result = 1'b1;
                    res        = frame_result(KIND_PAYLOAD, b, pay_count, fin);
                    pay_count  = pay_count + 6'd1;
                    if (fin)
                        frame_phase = FR_IDLE;
                end
                default:
                    frame_phase = FR_IDLE;
            endcase
        end
    endfunction

    function automatic string describe_result(input out_beat_t r);
        return {$sformatf("kind=%0d snd=%02h tgt=%02h ackrx=%b ackrq=%b ",
                          r.kind, r.sender_id, r.target_id, r.ack_received,
                          r.ack_requested),
                $sformatf("len=%0d data=%02h idx=%0d last=%b",
                          r.data_length, r.data_byte, r.byte_index, r.last)};
    endfunction

    function automatic bit result_matches(input out_beat_t got, input out_beat_t exp_r);
        return got.kind === exp_r.kind && got.sender_id === exp_r.sender_id &&
               got.target_id === exp_r.target_id && got.ack_received === exp_r.ack_received &&
               got.ack_requested === exp_r.ack_requested &&
               got.data_length === exp_r.data_length && got.data_byte === exp_r.data_byte &&
               got.byte_index === exp_r.byte_index && got.last === exp_r.last;
    endfunction

    function automatic void log_mismatch(input string what, input out_beat_t exp_r,
                                         input out_beat_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected %s | got %s", $time, what, describe_result(exp_r),
                     describe_result(got));
    endfunction

    // Monitor: check output beats, track register writes, predict input beats
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_phase  = FR_IDLE;
            frame_len    = '0;
            pay_count    = '0;
            frame_sender = '0;
            frame_target = '0;
            ack_bits     = '0;
            shadow_cfg   = '{8'h00, 1'b0, 8'hFF, 8'h80, 8'h40};
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    log_mismatch("unexpected result", NO_RESULT, out_data);
                else
                begin
                    want = expected_results.pop_front();
                    if (!result_matches(out_data, want))
                        log_mismatch("result mismatch", want, out_data);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NODE_ADDR:   shadow_cfg.node_address      = cfg_data;
                    REG_PROMISC:     shadow_cfg.promiscuous       = cfg_data[0];
                    REG_BCAST_ADDR:  shadow_cfg.broadcast_address = cfg_data;
                    REG_ACK_SENT:    shadow_cfg.ack_sent_mask     = cfg_data;
                    REG_ACK_REQUEST: shadow_cfg.ack_request_mask  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                deframe_beat(in_data, produced, predicted);
                if (produced)
                    expected_results.push_back(pinned_now ? pinned_result : predicted);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one beat, with random idle cycles ahead of it; returns once accepted
    task automatic send_beat(input logic [7:0] value, input bit start);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= in_beat_t'{value, start};
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_NODE_ADDR, c.node_address);
        write_reg(REG_PROMISC, {7'd0, c.promiscuous});
        write_reg(REG_BCAST_ADDR, c.broadcast_address);
        write_reg(REG_ACK_SENT, c.ack_sent_mask);
        write_reg(REG_ACK_REQUEST, c.ack_request_mask);
        cfg_valid <= 1'b0;
    endtask

    // Length byte, target, random sender and control, then n body bytes
    task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] target, input int n);
        send_beat(len_byte, 1'b1);
        send_beat(target, 1'b0);
        send_beat(8'($urandom_range(255)), 1'b0);
        send_beat(8'($urandom_range(255)), 1'b0);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(255)), 1'b0);
        frame_beats_sent += 4 + n;
    endtask

    // Mostly well-formed frames; some cut short, some with trailing strays, some noise
    task automatic send_random_frame;
        int         sel;
        int         body;
        logic [7:0] len_byte;
        logic [7:0] target;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        else
        begin
            sel = $urandom_range(99);
            if (sel < 70)
                len_byte = 8'($urandom_range(10, 0));
            else if (sel < 90)
                len_byte = 8'($urandom_range(66, 11));
            else
                len_byte = 8'($urandom_range(255, 67));
            sel = $urandom_range(99);
            if (sel < 40)
                target = shadow_cfg.node_address;
            else if (sel < 65)
                target = shadow_cfg.broadcast_address;
            else
                target = 8'($urandom_range(255));
            body = (len_byte > MAX_LEN) ? int'(MAX_LEN) : int'(len_byte);
            body = (body >= int'(HEADER_LEN)) ? body - int'(HEADER_LEN) : 0;
            sel = $urandom_range(99);
            if (sel < 10)
                body = $urandom_range(body, 0);
            else if (sel < 20)
                body = body + $urandom_range(3, 1);
            send_frame(len_byte, target, body);
        end
    endtask

    // Stimulus
    initial
    begin
        cfg_t phase_cfg;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        pinned_now    <= 1'b0;
        pinned_result <= '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_off_req   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under reset register values
        foreach (directed_rows[i])
        begin
            pinned_now    <= directed_rows[i].pinned;
            pinned_result <= directed_rows[i].result;
            send_beat(directed_rows[i].fifo_byte, directed_rows[i].frame_start);
        end
        pinned_now <= 1'b0;
        wait_drain();

        // Random phases, each under its own register setting and idling mode
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    phase_cfg     = '{8'h5A, 1'b0, 8'hFF, 8'h80, 8'h40};
                end
                1:
                begin
                    send_idle_pct = 65;
                    stall_pct     = 0;
                    phase_cfg     = '{8'hFF, 1'b1, 8'h00, 8'hFF, 8'h00};
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 65;
                    phase_cfg     = '{8'h00, 1'b0, 8'h00, 8'h00, 8'hFF};
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct     = 14;
                    phase_cfg     = '{8'($urandom_range(255)), 1'($urandom_range(1)),
                                      8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255))};
                end
            endcase
            load_config(phase_cfg);
            @(posedge clk);

            // Receiver holds off while a long frame keeps coming, then sender pauses
            if (p == 0)
            begin
                hold_off_req = 1'b1;
                send_frame(8'd30, phase_cfg.node_address, 27);
                wait_drain();
            end

            frame_beats_sent = 0;
            while (frame_beats_sent < ITEMS_PER_PHASE)
                send_random_frame();
            wait_drain();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
